// ===== hw/rtl/olist_pkg.sv =====
// Shared constants, codes and types for the ordered list block.
package olist_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_BADPOS  = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PLACE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/ordered_list_insert_delete_find.sv =====
// Ordered list with push, insert, delete-first-match and find-first-match.
//
// Input beats arrive on s_axis (opcode in tuser, position and value in tdata);
// each beat yields exactly one result beat on m_axis (status in tuser, found
// index and entry count in tdata). The list lives in a 64-entry single-port-
// write, registered-read memory and one read/compare/write step is done per
// cycle by a small sequencer, so the block takes one beat at a time.
// Push, a tail-append insert and any rejected op go straight to the done
// state. Other inserts move entries up from the tail to the insert point,
// then place the value; find and delete scan from index 0, find stopping
// at its first match. The memory read port limits the work: one entry is
// read and compared or moved per cycle. The result sits in an output
// register; a new beat is accepted while it waits, but a second result
// holds in the done state until the receiver takes the first. Reset empties
// the list and drops any pending result; the memory contents are not
// cleared and need no clearing pass.
module ordered_list_insert_delete_find
  import olist_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] position, [47:16] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] found_index, [12:6] entry_count, rest 0
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rdata;

  state_t            state, state_next;
  logic [1:0]        op, op_next;
  logic [ELEM_W-1:0] elem, elem_next;
  logic [ADDR_W-1:0] at, at_next;
  logic [ADDR_W-1:0] rd_ptr, rd_ptr_next;
  logic              found, found_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [1:0]        status, status_next;
  logic [CNT_W-1:0]  count, count_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ELEM_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              load_out;

  logic [15:0]       in_pos;
  logic [ELEM_W-1:0] in_elem;
  logic [16:0]       pos_limit;
  logic              hit, last;

  assign in_pos    = s_axis_tdata[15:0];
  assign in_elem   = s_axis_tdata[16 +: ELEM_W];
  assign pos_limit = 17'(count) + 17'd1;
  assign hit       = !found && (rdata == elem);
  assign last      = (CNT_W'(rd_ptr) == count - CNT_W'(1));

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      found  <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      found  <= found_next;
    end
    op     <= op_next;
    elem   <= elem_next;
    at     <= at_next;
    rd_ptr <= rd_ptr_next;
    idx    <= idx_next;
    status <= status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tuser <= status;
      m_axis_tdata <= {3'b0, 7'(count), 6'(idx)};
    end
  end

  always_comb begin
    state_next  = state;
    op_next     = op;
    elem_next   = elem;
    at_next     = at;
    rd_ptr_next = rd_ptr;
    found_next  = found;
    idx_next    = idx;
    status_next = status;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = elem;
    rd_addr     = rd_ptr;
    load_out    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_next     = s_axis_tuser;
          elem_next   = in_elem;
          at_next     = ADDR_W'(in_pos - 16'd1);
          found_next  = 1'b0;
          idx_next    = '0;
          status_next = STAT_OK;
          state_next  = S_DONE;
          unique case (s_axis_tuser)
            OP_PUSH: begin
              if (count >= CNT_W'(DEPTH)) begin
                status_next = STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(count);
                wr_data    = in_elem;
                count_next = count + CNT_W'(1);
              end
            end
            OP_INSERT: begin
              if (in_pos == 16'd0 || 17'(in_pos) > pos_limit) begin
                status_next = STAT_BADPOS;
              end else if (count >= CNT_W'(DEPTH)) begin
                status_next = STAT_FULL;
              end else if (17'(in_pos) == pos_limit) begin
                // append at the tail, nothing to move
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(count);
                wr_data    = in_elem;
                count_next = count + CNT_W'(1);
              end else begin
                rd_addr     = ADDR_W'(count - CNT_W'(1));
                rd_ptr_next = rd_addr;
                state_next  = S_SHIFT;
              end
            end
            default: begin
              if (count == '0) begin
                status_next = STAT_MISSING;
              end else begin
                rd_addr     = '0;
                rd_ptr_next = '0;
                state_next  = S_SCAN;
              end
            end
          endcase
        end
      end

      // move entries up one slot, from the tail down to the insert point
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = rd_ptr + ADDR_W'(1);
        wr_data = rdata;
        if (rd_ptr == at) begin
          state_next = S_PLACE;
        end else begin
          rd_addr     = rd_ptr - ADDR_W'(1);
          rd_ptr_next = rd_addr;
        end
      end

      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = at;
        wr_data    = elem;
        count_next = count + CNT_W'(1);
        state_next = S_DONE;
      end

      // compare each entry; on delete, entries past the match move down
      S_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          idx_next   = rd_ptr;
        end else if (found) begin
          wr_en   = 1'b1;
          wr_addr = rd_ptr - ADDR_W'(1);
          wr_data = rdata;
        end
        if (hit && op == OP_FIND) begin
          status_next = STAT_OK;
          state_next  = S_DONE;
        end else if (last) begin
          state_next = S_DONE;
          if (found || hit) begin
            status_next = STAT_OK;
            count_next  = count - CNT_W'(1);
          end else begin
            status_next = STAT_MISSING;
          end
        end else begin
          rd_addr     = rd_ptr + ADDR_W'(1);
          rd_ptr_next = rd_addr;
        end
      end

      S_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
